/* hdl/cpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

   // Field widths
   localparam int KIND_W      = 2;
   localparam int TEMP_W      = 12;
   localparam int MODE_W      = 3;
   localparam int SETPOINT_W  = 7;
   localparam int OFFSET_W    = 4;
   localparam int TIME_W      = 24;
   localparam int FRAC_W      = 4;
   localparam int EDGE_W      = SETPOINT_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int DEF_TIMER_BITS = 24;

   // Input kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEMP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

   // Modes
   localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WORK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REST  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CONT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FAULT = 3'd6;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_OFFSET   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_ON_WAIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RUN_TIME  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REST_TIME     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTART_WAIT  = 3'd5;

   // Register reset values
   localparam logic signed [SETPOINT_W-1:0] SETPOINT_RST = 7'sd5;
   localparam logic [OFFSET_W-1:0]   BAND_OFFSET_RST   = 4'd2;
   localparam logic [TIME_W-1:0]     POWER_ON_WAIT_RST = 24'd60;
   localparam logic [TIME_W-1:0]     MAX_RUN_TIME_RST  = 24'd7200;
   localparam logic [TIME_W-1:0]     REST_TIME_RST     = 24'd600;
   localparam logic [TIME_W-1:0]     RESTART_WAIT_RST  = 24'd300;

   typedef struct packed {
      logic signed [SETPOINT_W-1:0] setpoint;
      logic [OFFSET_W-1:0]          band_offset;
      logic [TIME_W-1:0]            power_on_wait;
      logic [TIME_W-1:0]            max_run_time;
      logic [TIME_W-1:0]            rest_time;
      logic [TIME_W-1:0]            restart_wait;
   } cfg_type;

   typedef struct packed {
      logic              compressor_on;
      logic [MODE_W-1:0] mode;
      logic              sensor_fault;
   } res_type;

endpackage

`default_nettype wire

/* hdl/cpt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpt_ctrl
   import cpt_pkg::*;
#(
   parameter int TIMER_BITS = DEF_TIMER_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     fire,
   input  wire logic [KIND_W-1:0]        kind,
   input  wire logic signed [TEMP_W-1:0] temperature,
   output      res_type                  res
);

   localparam int EXT_W = TIME_W + TIMER_BITS;

   // Clamp a tick count to the all-ones timer value.
   function automatic logic [TIMER_BITS-1:0] load_val(input logic [TIME_W-1:0] ticks);
      logic [EXT_W-1:0] ext;
      ext = {{TIMER_BITS{1'b0}}, ticks};
      if (|ext[EXT_W-1:TIMER_BITS]) begin
         load_val = '1;
      end else begin
         load_val = ext[TIMER_BITS-1:0];
      end
   endfunction

   logic [MODE_W-1:0]        mode_ff,  mode_in;
   logic [TIMER_BITS-1:0]    timer_ff, timer_in;
   logic signed [TEMP_W-1:0] temp_ff,  temp_in;
   logic                     fault_ff, fault_in;

   logic [EDGE_W-1:0]        stop_whole, start_whole;
   logic signed [TEMP_W-1:0] stop_edge, start_edge;
   logic                     running;
   logic                     do_eval;

   // Band edges in 1/16 degree, exact
   assign stop_whole  = EDGE_W'($signed(cfg.setpoint)) - EDGE_W'(cfg.band_offset);
   assign start_whole = EDGE_W'($signed(cfg.setpoint)) + EDGE_W'(cfg.band_offset);
   assign stop_edge   = $signed({stop_whole, {FRAC_W{1'b0}}});
   assign start_edge  = $signed({start_whole, {FRAC_W{1'b0}}});

   assign running = mode_ff inside {MODE_INIT, MODE_WORK, MODE_REST, MODE_WAIT, MODE_FAULT};

   always_comb begin
      mode_in  = mode_ff;
      timer_in = timer_ff;
      temp_in  = temp_ff;
      fault_in = fault_ff;
      do_eval  = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (running) begin
               if (timer_ff <= TIMER_BITS'(1)) begin
                  case (mode_ff)
                     MODE_INIT: begin
                        mode_in = MODE_READY;
                        do_eval = 1'b1;
                     end
                     MODE_WORK: begin
                        mode_in  = MODE_REST;
                        timer_in = load_val(cfg.rest_time);
                     end
                     MODE_REST: begin
                        mode_in = MODE_CONT;
                        do_eval = 1'b1;
                     end
                     MODE_WAIT: begin
                        mode_in = MODE_READY;
                        do_eval = 1'b1;
                     end
                     MODE_FAULT: begin
                        mode_in = MODE_CONT;
                        do_eval = 1'b1;
                     end
                     default: begin
                        mode_in = mode_ff;
                     end
                  endcase
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
         end
         KIND_TEMP: begin
            fault_in = 1'b0;
            temp_in  = temperature;
            do_eval  = 1'b1;
         end
         KIND_FAULT: begin
            fault_in = 1'b1;
            if (mode_ff == MODE_WORK) begin
               mode_in  = MODE_FAULT;
               timer_in = load_val(cfg.restart_wait);
            end
         end
         default: begin
            do_eval = 1'b0;
         end
      endcase

      // Re-evaluate start and stop against the band
      if (do_eval && !fault_in && mode_in != MODE_INIT) begin
         if (mode_in == MODE_WORK && temp_in <= stop_edge) begin
            mode_in  = MODE_WAIT;
            timer_in = load_val(cfg.restart_wait);
         end else if (mode_in == MODE_READY && temp_in >= start_edge) begin
            mode_in  = MODE_WORK;
            timer_in = load_val(cfg.max_run_time);
         end else if (mode_in == MODE_CONT && temp_in > stop_edge) begin
            mode_in  = MODE_WORK;
            timer_in = load_val(cfg.max_run_time);
         end
      end
   end

   assign res.compressor_on = (mode_in == MODE_WORK);
   assign res.mode          = mode_in;
   assign res.sensor_fault  = fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_INIT;
         timer_ff <= load_val(POWER_ON_WAIT_RST);
         temp_ff  <= '0;
         fault_ff <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         timer_ff <= timer_in;
         temp_ff  <= temp_in;
         fault_ff <= fault_in;
      end
   end

   a_fault_sets_flag: assert property (@(posedge clock) disable iff (reset)
      fire && kind == KIND_FAULT |=> fault_ff)
      else $error("fault event did not set the fault flag");

   a_fault_stops_work: assert property (@(posedge clock) disable iff (reset)
      fire && kind == KIND_FAULT && mode_ff == MODE_WORK |=> mode_ff == MODE_FAULT)
      else $error("fault while running did not stop the compressor");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(timer_ff))
      else $error("state moved without an event");

endmodule

`default_nettype wire

/* hdl/compressor_protection_thermostat_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A beat accepted on req_ passes through the input register and then the result register before it shows on rsp_.
// Throughput: one beat per cycle while req_stall is low; the whole event update is a single compare-and-select pass.
// A two-entry result stage (output register plus skid) lets req_ keep moving while rsp_ stalls.
// Reset (synchronous, active high): mode init, timer loaded with the default power-on wait,
// last temperature 0, fault flag clear, all registers at their defaults, both channels empty.
module compressor_protection_thermostat_unit
   import cpt_pkg::*;
#(
   parameter int TIMER_BITS = DEF_TIMER_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // event channel
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic signed [TEMP_W-1:0] req_temperature,
   // result channel
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_compressor_on,
   output      logic [MODE_W-1:0]        rsp_mode,
   output      logic                     rsp_sensor_fault,
   // register write channel
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers. The user must write them only while the block is
   // idle; the block does not enforce this and always takes the writes.
   // ---------------------------------------------------------------------
   cfg_type cfg_ff;
   logic    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint      <= SETPOINT_RST;
         cfg_ff.band_offset   <= BAND_OFFSET_RST;
         cfg_ff.power_on_wait <= POWER_ON_WAIT_RST;
         cfg_ff.max_run_time  <= MAX_RUN_TIME_RST;
         cfg_ff.rest_time     <= REST_TIME_RST;
         cfg_ff.restart_wait  <= RESTART_WAIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SETPOINT:      cfg_ff.setpoint      <= $signed(csr_data[SETPOINT_W-1:0]);
            CSR_BAND_OFFSET:   cfg_ff.band_offset   <= csr_data[OFFSET_W-1:0];
            CSR_POWER_ON_WAIT: cfg_ff.power_on_wait <= csr_data[TIME_W-1:0];
            CSR_MAX_RUN_TIME:  cfg_ff.max_run_time  <= csr_data[TIME_W-1:0];
            CSR_REST_TIME:     cfg_ff.rest_time     <= csr_data[TIME_W-1:0];
            CSR_RESTART_WAIT:  cfg_ff.restart_wait  <= csr_data[TIME_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. Hold the beat while the result stage is full.
   // ---------------------------------------------------------------------
   logic                     in_valid_ff, in_valid_in;
   logic [KIND_W-1:0]        in_kind_ff;
   logic signed [TEMP_W-1:0] in_temp_ff;
   logic                     req_accept;

   logic    out_valid_ff,  out_valid_in;
   res_type out_res_ff,    out_res_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type skid_res_ff,   skid_res_in;

   logic    fire;
   logic    drain;
   logic    out_free;
   res_type res;

   // Stall depends on registers only: a held input with a full skid entry.
   assign req_stall   = in_valid_ff && skid_valid_ff;
   assign req_accept  = req_valid && !req_stall;
   assign fire        = in_valid_ff && !skid_valid_ff;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_kind;
         in_temp_ff <= req_temperature;
      end
   end

   // ---------------------------------------------------------------------
   // Event update: mode, timer, last reading, fault flag.
   // ---------------------------------------------------------------------
   cpt_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fire        (fire),
      .kind        (in_kind_ff),
      .temperature (in_temp_ff),
      .res         (res)
   );

   // ---------------------------------------------------------------------
   // Result stage: output register plus one skid entry.
   // ---------------------------------------------------------------------
   assign drain    = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || drain;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // advance the parked result first to keep order
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else if (fire) begin
            out_valid_in = 1'b1;
            out_res_in   = res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (fire) begin
         // output held by a stall: park the new result
         skid_valid_in = 1'b1;
         skid_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_compressor_on = out_res_ff.compressor_on;
   assign rsp_mode          = out_res_ff.mode;
   assign rsp_sensor_fault  = out_res_ff.sensor_fault;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output is empty");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      fire && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("result lost while the output was stalled");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff && out_valid_ff)
      else $error("skid entry did not advance after the output drained");

endmodule

`default_nettype wire

/* tb/thermostat_status_checker.sv */
`timescale 1ns / 1ps

module thermostat_status_checker
   import cpt_pkg::*;
#(
   parameter int TIMER_BITS = DEF_TIMER_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_compressor_on,
   input  logic [MODE_W-1:0]        rsp_mode,
   input  logic                     rsp_sensor_fault,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output int                       mismatches,
   output int                       outstanding
);

   cfg_type                  regs;
   logic [MODE_W-1:0]        mode_now;
   logic [TIMER_BITS-1:0]    countdown;
   logic signed [TEMP_W-1:0] last_reading;
   logic                     fault_seen;
   res_type                  status_queue[$];
   res_type                  head;

   // saturate loads that do not fit the timer
   function automatic void arm_timer(input logic [TIME_W-1:0] ticks);
      longint ceiling;
      ceiling = (longint'(1) << TIMER_BITS) - 1;
      if (longint'(ticks) > ceiling) countdown = ceiling[TIMER_BITS-1:0];
      else countdown = TIMER_BITS'(ticks);
   endfunction

   // hysteresis decision against the latest reading
   function automatic void check_band();
      int sp;
      int stop_at;
      int start_at;
      int reading;
      if (fault_seen || mode_now == MODE_INIT) return;
      sp       = int'(regs.setpoint);
      stop_at  = (sp - int'(regs.band_offset)) * (1 << FRAC_W);
      start_at = (sp + int'(regs.band_offset)) * (1 << FRAC_W);
      reading  = int'(last_reading);
      if (mode_now == MODE_WORK && reading <= stop_at) begin
         mode_now = MODE_WAIT;
         arm_timer(regs.restart_wait);
      end else if (mode_now == MODE_READY && reading >= start_at) begin
         mode_now = MODE_WORK;
         arm_timer(regs.max_run_time);
      end else if (mode_now == MODE_CONT && reading > stop_at) begin
         mode_now = MODE_WORK;
         arm_timer(regs.max_run_time);
      end
   endfunction

   function automatic void timer_expired();
      case (mode_now)
         MODE_INIT: begin
            mode_now = MODE_READY;
            check_band();
         end
         MODE_WORK: begin
            mode_now = MODE_REST;
            arm_timer(regs.rest_time);
         end
         MODE_REST, MODE_FAULT: begin
            mode_now = MODE_CONT;
            check_band();
         end
         MODE_WAIT: begin
            mode_now = MODE_READY;
            check_band();
         end
         default: ;
      endcase
   endfunction

   function automatic res_type advance_thermostat(input logic [KIND_W-1:0] kind,
                                                 input logic signed [TEMP_W-1:0] reading);
      res_type status;
      case (kind)
         KIND_TICK: begin
            if (mode_now == MODE_INIT || mode_now == MODE_WORK || mode_now == MODE_REST ||
                mode_now == MODE_WAIT || mode_now == MODE_FAULT) begin
               if (countdown <= 1) timer_expired();
               else countdown = countdown - 1'b1;
            end
         end
         KIND_TEMP: begin
            fault_seen   = 1'b0;
            last_reading = reading;
            check_band();
         end
         KIND_FAULT: begin
            fault_seen = 1'b1;
            if (mode_now == MODE_WORK) begin
               mode_now = MODE_FAULT;
               arm_timer(regs.restart_wait);
            end
         end
         default: ;
      endcase
      status.compressor_on = (mode_now == MODE_WORK);
      status.mode          = mode_now;
      status.sensor_fault  = fault_seen;
      return status;
   endfunction

   task automatic compare_field(input string label, input logic [MODE_W-1:0] want,
                                input logic [MODE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.setpoint      = SETPOINT_RST;
         regs.band_offset   = BAND_OFFSET_RST;
         regs.power_on_wait = POWER_ON_WAIT_RST;
         regs.max_run_time  = MAX_RUN_TIME_RST;
         regs.rest_time     = REST_TIME_RST;
         regs.restart_wait  = RESTART_WAIT_RST;
         mode_now           = MODE_INIT;
         last_reading       = '0;
         fault_seen         = 1'b0;
         arm_timer(POWER_ON_WAIT_RST);
         status_queue.delete();
         mismatches  = 0;
         outstanding = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SETPOINT:      regs.setpoint      = csr_data[SETPOINT_W-1:0];
               CSR_BAND_OFFSET:   regs.band_offset   = csr_data[OFFSET_W-1:0];
               CSR_POWER_ON_WAIT: regs.power_on_wait = csr_data[TIME_W-1:0];
               CSR_MAX_RUN_TIME:  regs.max_run_time  = csr_data[TIME_W-1:0];
               CSR_REST_TIME:     regs.rest_time     = csr_data[TIME_W-1:0];
               CSR_RESTART_WAIT:  regs.restart_wait  = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            status_queue.push_back(advance_thermostat(req_kind, req_temperature));
         if (rsp_valid && !rsp_stall) begin
            if (status_queue.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual mode %0d", $time, rsp_mode);
               mismatches++;
            end else begin
               head = status_queue.pop_front();
               compare_field("compressor_on", MODE_W'(head.compressor_on),
                             MODE_W'(rsp_compressor_on));
               compare_field("mode", head.mode, rsp_mode);
               compare_field("sensor_fault", MODE_W'(head.sensor_fault),
                             MODE_W'(rsp_sensor_fault));
            end
         end
         outstanding = status_queue.size();
      end
   end

endmodule

/* tb/compressor_protection_thermostat_unit_tb.sv */
`timescale 1ns / 1ps

module compressor_protection_thermostat_unit_tb;
   import cpt_pkg::*;

   // kind code the block must ignore, and register slots past the list
   localparam logic [KIND_W-1:0]      KIND_SPARE   = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // limit on the length of the whole run, set with a wide margin
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind = '0;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_compressor_on;
   logic [MODE_W-1:0]        rsp_mode;
   logic                     rsp_sensor_fault;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   int   mismatches;
   int   pending;
   int   cycle_count = 0;
   bit   sender_gaps = 1'b1;
   bit   stall_enable = 1'b1;
   int   cur_setpoint = 5;
   int   cur_band = 2;
   int   phase;
   int   n;
   int   sp_pick;

   compressor_protection_thermostat_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_temperature   (req_temperature),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compressor_on (rsp_compressor_on),
      .rsp_mode          (rsp_mode),
      .rsp_sensor_fault  (rsp_sensor_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   thermostat_status_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_temperature   (req_temperature),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compressor_on (rsp_compressor_on),
      .rsp_mode          (rsp_mode),
      .rsp_sensor_fault  (rsp_sensor_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .outstanding       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random on every falling edge; stall_enable is
   // updated with nonblocking writes so this always reads a settled value.
   always @(negedge clock) begin
      rsp_stall <= stall_enable && ($urandom_range(99) < 31);
   end

   // Watchdog: a hung handshake or a lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Write one register and hold until the block takes it. Runs from a
   // falling edge and returns on a falling edge with the channel quiet.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Load a full register set; remember the band so stimulus can aim at it.
   task automatic configure(input int sp, input int band, input logic [TIME_W-1:0] por,
                            input logic [TIME_W-1:0] run_max, input logic [TIME_W-1:0] rest,
                            input logic [TIME_W-1:0] restart);
      logic [CSR_DATA_W-1:0] word;
      word = '0;
      word[SETPOINT_W-1:0] = sp[SETPOINT_W-1:0];
      write_reg(CSR_SETPOINT, word);
      word = '0;
      word[OFFSET_W-1:0] = band[OFFSET_W-1:0];
      write_reg(CSR_BAND_OFFSET, word);
      write_reg(CSR_POWER_ON_WAIT, por);
      write_reg(CSR_MAX_RUN_TIME, run_max);
      write_reg(CSR_REST_TIME, rest);
      write_reg(CSR_RESTART_WAIT, restart);
      cur_setpoint = sp;
      cur_band     = band;
   endtask

   // Offer one event beat. Valid is only raised or dropped once per falling
   // edge: gaps drop it, the beat raises it, and it stays up into the next
   // beat when no gap follows.
   task automatic push_event(input logic [KIND_W-1:0] kind,
                             input logic signed [TEMP_W-1:0] reading);
      while (sender_gaps && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_temperature <= reading;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic push_ticks(input int count);
      repeat (count) push_event(KIND_TICK, TEMP_W'($urandom()));
   endtask

   // Drop valid and hold until every predicted status has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Aim most readings at the stop and start edges, some inside the band,
   // the rest anywhere in the 12-bit range.
   function automatic logic signed [TEMP_W-1:0] pick_temperature();
      int stop_at;
      int start_at;
      int r;
      int v;
      stop_at  = (cur_setpoint - cur_band) * (1 << FRAC_W);
      start_at = (cur_setpoint + cur_band) * (1 << FRAC_W);
      r = $urandom_range(99);
      if (r < 30) v = stop_at + int'($urandom_range(4)) - 2;
      else if (r < 60) v = start_at + int'($urandom_range(4)) - 2;
      else if (r < 80) v = stop_at + int'($urandom_range(start_at - stop_at));
      else v = $urandom();
      return v[TEMP_W-1:0];
   endfunction

   task automatic random_event();
      int r;
      r = $urandom_range(99);
      if (r < 45) push_event(KIND_TICK, TEMP_W'($urandom()));
      else if (r < 83) push_event(KIND_TEMP, pick_temperature());
      else if (r < 95) push_event(KIND_FAULT, TEMP_W'($urandom()));
      else push_event(KIND_SPARE, TEMP_W'($urandom()));
   endtask

   initial begin
      // hold reset, then release it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Still in power-on wait: extreme readings, a fault outside work,
      // the unused kind, one tick, and a reading that clears the fault.
      push_event(KIND_TEMP, 12'sh7FF);
      push_event(KIND_TEMP, 12'sh800);
      push_event(KIND_FAULT, '0);
      push_event(KIND_SPARE, 12'sh555);
      push_event(KIND_TICK, 12'shAAA);
      push_event(KIND_TEMP, '0);
      drain();

      // Short protection times; a zero restart wait expires on the next
      // tick. The new power-on wait must not reload the running timer.
      configure(5, 2, 24'd5, 24'd3, 24'd2, 24'd0);

      // Reading right on the start edge, then finish the power-on wait:
      // expiry lands in ready and starts at once.
      push_event(KIND_TEMP, 12'sd112);
      push_ticks(59);
      // exactly on the stop edge: stop and wait
      push_event(KIND_TEMP, 12'sd48);
      push_ticks(1);
      // idle tick in ready, one below the start edge, then on it
      push_ticks(1);
      push_event(KIND_TEMP, 12'sd111);
      push_event(KIND_TEMP, 12'sd112);
      // fault while running, wait out, fault still latched in continue
      push_event(KIND_FAULT, '0);
      push_ticks(2);
      // on the stop edge stays in continue, one above restarts
      push_event(KIND_TEMP, 12'sd48);
      push_event(KIND_TEMP, 12'sd49);
      // run the maximum time, rest, continue back into work
      push_ticks(5);
      drain();

      for (phase = 0; phase < 7; phase++) begin
         sender_gaps  = 1'b1;
         stall_enable <= 1'b1;
         case (phase)
            0: configure(-64, 15, TIME_W'($urandom()), TIME_W'($urandom_range(1, 5)),
                         TIME_W'($urandom_range(1, 5)), TIME_W'($urandom_range(1, 5)));
            1: configure(63, 0, TIME_W'($urandom()), 24'd0, 24'd0, 24'd0);
            // timers at full scale never expire within the run
            2: configure($urandom_range(100) - 40, $urandom_range(15), 24'hFFFFFF,
                         24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            3: begin
               configure($urandom_range(100) - 40, $urandom_range(15), TIME_W'($urandom()),
                         TIME_W'($urandom_range(1, 6)), TIME_W'($urandom_range(1, 6)),
                         TIME_W'($urandom_range(1, 6)));
               // long stretch with both sides streaming
               sender_gaps  = 1'b0;
               stall_enable <= 1'b0;
            end
            4: begin
               sp_pick = $urandom_range(127);
               if (sp_pick > 63) sp_pick -= 128;
               configure(sp_pick, $urandom_range(15), TIME_W'($urandom()),
                         TIME_W'($urandom_range(1, 8)), TIME_W'($urandom_range(1, 8)),
                         TIME_W'($urandom_range(1, 8)));
               // writes past the register list must leave everything alone
               write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom()));
               write_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom()));
            end
            5: configure(0, 0, 24'd1, 24'd1, 24'd1, 24'd1);
            default: configure($urandom_range(100) - 40, $urandom_range(15),
                               TIME_W'($urandom()), TIME_W'($urandom_range(1, 6)),
                               TIME_W'($urandom_range(1, 6)),
                               TIME_W'($urandom_range(1, 6)));
         endcase
         for (n = 0; n < 138; n++) begin
            // halfway through the last phase, hold off until all beats are back
            if (phase == 6 && n == 69) drain();
            random_event();
         end
         drain();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
